// ===== sv/wdt_pkg.sv =====
package wdt_pkg;

   // Table geometry.
   localparam int NUM_TIMERS = 16;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

   // Field widths.
   localparam int CMD_W     = 3;
   localparam int STAT_W    = 3;
   localparam int REQ_IDX_W = 4;
   localparam int DELAY_W   = 32;
   localparam int TICK_W    = DELAY_W - 1;
   localparam int HND_W     = 16;
   localparam int PRM_W     = 32;
   localparam int PAY_W     = HND_W + PRM_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE = 3'd0,
      CMD_DELETE = 3'd1,
      CMD_START  = 3'd2,
      CMD_CANCEL = 3'd3,
      CMD_TICK   = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_INVALID = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_EXPIRY  = 3'd3,
      STAT_QUIET   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      status_type             status;
      logic [REQ_IDX_W-1:0]   index;
      logic [HND_W-1:0]       handler;
      logic [PRM_W-1:0]       param;
      logic                   last;
   } result_type;

   // Half the requested delay, truncated toward zero, and never below one tick.
   function automatic logic [TICK_W-1:0] half_delay(input logic [DELAY_W-1:0] d);
      logic [TICK_W-1:0] mag;
      mag = d[DELAY_W-1:1];
      if (d[DELAY_W-1] || (mag == '0)) begin
         return TICK_W'(1);
      end
      return mag;
   endfunction

endpackage

// ===== sv/wdt_ram.sv =====
module wdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port; read data holds while re is low.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/watchdog_timer_table_core.sv =====
// Create, delete, start and cancel: the result passes through the held-result register and
// then the output register; the next transaction is taken once it is in the output register.
// Tick: one pass over the tick and handler memories, one slot per cycle while no expiry
// waits behind a held one for the output register; expiries stream out during the pass.
// The closing result follows the pass; the next transaction is taken once it is in the output register.
// Synchronous active-high reset clears all slot-in-use flags and the control state;
// the tick, handler and parameter memories are not cleared and need no clearing pass.
module watchdog_timer_table_core
   import wdt_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [CMD_W-1:0]            req_command,
   input  logic [REQ_IDX_W-1:0]        req_timer_index,
   input  logic signed [DELAY_W-1:0]   req_delay,
   input  logic [HND_W-1:0]            req_handler_id,
   input  logic signed [PRM_W-1:0]     req_handler_param,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STAT_W-1:0]           rsp_status,
   output logic [REQ_IDX_W-1:0]        rsp_result_index,
   output logic [HND_W-1:0]            rsp_expired_handler,
   output logic signed [PRM_W-1:0]     rsp_expired_param,
   output logic                        rsp_last
);

   fsm_type                state_ff, state_in;
   logic [NUM_TIMERS-1:0]  in_use_ff, in_use_in;
   result_type             out_ff, out_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             pend_ff, pend_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]       proc_idx_ff, proc_idx_in;

   logic                   accept;
   logic                   out_free;
   cmd_type                cmd;
   logic [IDX_W-1:0]       slot;
   logic                   slot_ok;
   logic                   free_found;
   logic [IDX_W-1:0]       free_slot;

   result_type             cmd_res;
   logic                   set_use, clr_use;
   logic                   acc_we, acc_pay_we;
   logic [IDX_W-1:0]       acc_waddr;
   logic [TICK_W-1:0]      acc_wticks;

   logic                   ticks_we, ticks_re, pay_we;
   logic [IDX_W-1:0]       ticks_waddr, ticks_raddr;
   logic [TICK_W-1:0]      ticks_wdata, ticks_rdata;
   logic [PAY_W-1:0]       pay_wdata, pay_rdata;

   logic [TICK_W-1:0]      p_ticks;
   logic [HND_W-1:0]       p_handler;
   logic [PRM_W-1:0]       p_param;
   logic                   p_active, p_expire;
   result_type             exp_res;
   logic                   stall, advance;
   logic                   scan_done;

   // Tick counts, and handler with parameter, in two small memories.
   wdt_ram #(.WIDTH(TICK_W), .DEPTH(NUM_TIMERS)) u_ticks_ram (
      .clock (clock),
      .we    (ticks_we),
      .waddr (ticks_waddr),
      .wdata (ticks_wdata),
      .re    (ticks_re),
      .raddr (ticks_raddr),
      .rdata (ticks_rdata)
   );

   wdt_ram #(.WIDTH(PAY_W), .DEPTH(NUM_TIMERS)) u_pay_ram (
      .clock (clock),
      .we    (pay_we),
      .waddr (acc_waddr),
      .wdata (pay_wdata),
      .re    (ticks_re),
      .raddr (ticks_raddr),
      .rdata (pay_rdata)
   );

   assign req_ready = (state_ff == FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign cmd       = cmd_type'(req_command);
   assign slot      = req_timer_index[IDX_W-1:0];
   assign slot_ok   = (int'(req_timer_index) < NUM_TIMERS) && in_use_ff[slot];
   assign pay_wdata = {req_handler_id, req_handler_param};

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_slot  = IDX_W'(i);
         end
      end
   end

   // Decode of a single-result command at the accepting edge.
   always_comb begin
      cmd_res        = '0;
      cmd_res.status = STAT_INVALID;
      cmd_res.last   = 1'b1;
      set_use        = 1'b0;
      clr_use        = 1'b0;
      acc_we         = 1'b0;
      acc_pay_we     = 1'b0;
      acc_waddr      = slot;
      acc_wticks     = '0;
      case (cmd)
         CMD_CREATE: begin
            if (free_found) begin
               cmd_res.status = STAT_OK;
               cmd_res.index  = REQ_IDX_W'(free_slot);
               set_use        = 1'b1;
               acc_we         = 1'b1;
               acc_waddr      = free_slot;
            end else begin
               cmd_res.status = STAT_FULL;
            end
         end
         CMD_DELETE: begin
            if (slot_ok) begin
               cmd_res.status = STAT_OK;
               clr_use        = 1'b1;
            end
         end
         CMD_START: begin
            if (slot_ok) begin
               cmd_res.status = STAT_OK;
               acc_we         = 1'b1;
               acc_pay_we     = 1'b1;
               acc_wticks     = half_delay(req_delay);
            end
         end
         CMD_CANCEL: begin
            if (slot_ok) begin
               cmd_res.status = STAT_OK;
               acc_we         = 1'b1;
            end
         end
         CMD_TICK: begin
         end
         default: begin
         end
      endcase
   end

   // Slot under the scan: the registered read data arrives in the cycle after its address.
   assign p_ticks   = ticks_rdata;
   assign p_handler = pay_rdata[PAY_W-1:PRM_W];
   assign p_param   = pay_rdata[PRM_W-1:0];
   assign p_active  = proc_valid_ff && in_use_ff[proc_idx_ff] && (p_ticks != '0);
   assign p_expire  = p_active && (p_ticks == TICK_W'(1)) && (p_handler != '0);

   always_comb begin
      exp_res         = '0;
      exp_res.status  = STAT_EXPIRY;
      exp_res.index   = REQ_IDX_W'(proc_idx_ff);
      exp_res.handler = p_handler;
      exp_res.param   = p_param;
      exp_res.last    = 1'b0;
   end

   // An expiry behind a held one needs the output register free.
   assign stall     = p_expire && pend_valid_ff && !out_free;
   assign advance   = (state_ff == FSM_SCAN) && !stall;
   assign scan_done = (rd_cnt_ff == CNT_W'(NUM_TIMERS)) && !proc_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = (cmd == CMD_TICK) ? FSM_SCAN : FSM_FINISH;
            end
         end
         FSM_SCAN: begin
            if (scan_done) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Datapath control per state.
   always_comb begin
      in_use_in     = in_use_ff;
      ticks_we      = 1'b0;
      ticks_waddr   = acc_waddr;
      ticks_wdata   = acc_wticks;
      ticks_re      = 1'b0;
      ticks_raddr   = rd_cnt_ff[IDX_W-1:0];
      pay_we        = 1'b0;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      rd_cnt_in     = rd_cnt_ff;
      proc_valid_in = proc_valid_ff;
      proc_idx_in   = proc_idx_ff;
      case (state_ff)
         FSM_IDLE: begin
            rd_cnt_in     = '0;
            proc_valid_in = 1'b0;
            if (accept && (cmd != CMD_TICK)) begin
               ticks_we      = acc_we;
               pay_we        = acc_pay_we;
               pend_in       = cmd_res;
               pend_valid_in = 1'b1;
               if (set_use) begin
                  in_use_in[acc_waddr] = 1'b1;
               end
               if (clr_use) begin
                  in_use_in[acc_waddr] = 1'b0;
               end
            end
         end
         FSM_SCAN: begin
            if (advance) begin
               // Issue the read of the next slot.
               if (rd_cnt_ff < CNT_W'(NUM_TIMERS)) begin
                  ticks_re      = 1'b1;
                  proc_valid_in = 1'b1;
                  proc_idx_in   = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in     = rd_cnt_ff + CNT_W'(1);
               end else begin
                  proc_valid_in = 1'b0;
               end
               // Count down the slot whose data is here.
               if (p_active) begin
                  ticks_we    = 1'b1;
                  ticks_waddr = proc_idx_ff;
                  ticks_wdata = p_ticks - TICK_W'(1);
               end
               // Hold each expiry until the next one shows it is not the last.
               if (p_expire) begin
                  if (pend_valid_ff) begin
                     out_in       = pend_ff;
                     out_valid_in = 1'b1;
                  end
                  pend_in       = exp_res;
                  pend_valid_in = 1'b1;
               end
            end
         end
         FSM_FINISH: begin
            if (out_free) begin
               if (pend_valid_ff) begin
                  out_in = pend_ff;
               end else begin
                  out_in        = '0;
                  out_in.status = STAT_QUIET;
               end
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         in_use_ff     <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         proc_valid_ff <= 1'b0;
         rd_cnt_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
         proc_valid_ff <= proc_valid_in;
         rd_cnt_ff     <= rd_cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      pend_ff     <= pend_in;
      proc_idx_ff <= proc_idx_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_result_index    = out_ff.index;
   assign rsp_expired_handler = out_ff.handler;
   assign rsp_expired_param   = out_ff.param;
   assign rsp_last            = out_ff.last;

`ifndef NO_ASSERTIONS
   // Nothing is held or in flight once the block is back at rest.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_IDLE) |-> (!pend_valid_ff && !proc_valid_ff))
      else $error("held result or scan slot left over in idle");

   // A scan only writes back the slot whose data it holds, and only a slot in use.
   assert property (@(posedge clock) disable iff (reset)
      (ticks_we && (state_ff == FSM_SCAN)) |-> (proc_valid_ff && in_use_ff[proc_idx_ff]))
      else $error("tick write-back without a live slot");

   // The closing result of every transaction carries the last flag.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == FSM_FINISH) && out_free) |=> (rsp_valid && rsp_last))
      else $error("closing result without last flag");

   // The read counter never runs past the table.
   assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_W'(NUM_TIMERS))
      else $error("scan counter overran the table");
`endif

endmodule
